// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk_i, idle while reset is active.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds on a rising edge of clk_i outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== design/lgs_pkg.sv =====
// Shared widths and the neighborhood type for the life generation step block.
`default_nettype none

package lgs_pkg;

  localparam int unsigned DataW = 64;  // row width on the ports
  localparam int unsigned IdxW  = 6;   // row index width on the ports

  // Eight neighbors and the center of one cell.
  typedef struct packed {
    logic [2:0] above;  // west, center, east of the row above
    logic       west;
    logic       alive;
    logic       east;
    logic [2:0] below;  // west, center, east of the row below
  } nbhd_t;

endpackage

`default_nettype wire

// ===== design/lgs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lgs_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/lgs_lane.sv =====
// One cell lane: counts live neighbors and applies the B3/S23 rule.
`default_nettype none

module lgs_lane
  import lgs_pkg::*;
(
  input  wire nbhd_t nbhd_i,
  output logic       next_o
);

  logic [3:0] count;

  always_comb begin
    count = 4'(nbhd_i.above[0]) + 4'(nbhd_i.above[1]) + 4'(nbhd_i.above[2])
          + 4'(nbhd_i.west)     + 4'(nbhd_i.east)
          + 4'(nbhd_i.below[0]) + 4'(nbhd_i.below[1]) + 4'(nbhd_i.below[2]);
    // born with three, survive with two or three
    next_o = (count == 4'd3) || (nbhd_i.alive && (count == 4'd2));
  end

endmodule

`default_nettype wire

// ===== design/life_generation_step_top.sv =====
// Top level of the life generation step block: frame store, cell lanes, output register.
`default_nettype none
`include "assert_macros.svh"

// Rows of the current generation are taken one per cycle, row 0 first, and
// written to the frame store; no result comes out while rows arrive. The
// transfer of row ROWS-1 starts the run: the block then stops taking input.
// Row 1 is fetched from the frame store alongside that transfer, so its data
// is ready when emitting begins. From then on the block produces one
// next-generation row per cycle (COLS cell lanes evaluate a whole row at
// once) as long as the output side takes them, ROWS results in all, the last
// one flagged by last_of_run_o. Input is taken again once the last result is
// registered. Loading and emitting do not overlap: every row of a
// generation is loaded before any result of it is produced, and output
// stalls add to the emit phase. wrap_mode is sampled with the last
// row and holds for the whole run; it resets to 1 (toroidal).
module life_generation_step_top
  import lgs_pkg::*;
#(
  parameter int unsigned ROWS = 32,
  parameter int unsigned COLS = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [DataW-1:0]  row_bits_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [IdxW-1:0]   row_index_o,
  output logic      [DataW-1:0]  next_row_bits_o,
  output logic                   last_of_run_o
);

  localparam int unsigned RowAw = $clog2(ROWS);
  localparam logic [RowAw-1:0] LastRow = RowAw'(ROWS - 1);
  localparam logic [RowAw:0] LastRowX = (RowAw + 1)'(ROWS - 1);
  localparam logic [DataW-1:0] ColMask = {DataW{1'b1}} >> (DataW - COLS);

  typedef enum logic {StLoad, StEmit} state_e;

  state_e            state_q, state_d;
  logic              wrap_cfg_q, wrap_cfg_d;
  logic              wrap_q, wrap_d;
  logic [RowAw-1:0]  rows_q, rows_d;
  logic [RowAw-1:0]  emit_row_q, emit_row_d;
  logic [DataW-1:0]  row0_q, row0_d;
  logic [DataW-1:0]  above_q, above_d;
  logic [DataW-1:0]  cur_q, cur_d;
  logic              rd_vld_q, rd_vld_d;
  logic              out_valid_q, out_valid_d;
  logic [DataW-1:0]  out_row_q, out_row_d;
  logic [IdxW-1:0]   out_idx_q, out_idx_d;
  logic              out_last_q, out_last_d;

  logic              in_fire;
  logic              last_in;
  logic [DataW-1:0]  in_masked;
  logic              at_last;
  logic              below_ok;
  logic              step;
  logic [RowAw:0]    nxt2;
  logic              ram_re;
  logic [RowAw-1:0]  ram_raddr;
  logic [DataW-1:0]  ram_rdata;
  logic [DataW-1:0]  below;
  logic [DataW-1:0]  lane_row;

  assign in_ready_o = (state_q == StLoad);
  assign in_fire    = in_valid_i && in_ready_o;
  assign last_in    = (rows_q == LastRow);
  assign in_masked  = row_bits_i & ColMask;

  assign at_last  = (emit_row_q == LastRow);
  assign below_ok = at_last || rd_vld_q;
  assign below    = at_last ? (wrap_q ? row0_q : '0) : ram_rdata;
  assign step     = (state_q == StEmit) && below_ok && (!out_valid_q || out_ready_i);
  assign nxt2     = {1'b0, emit_row_q} + (RowAw + 1)'(2);

  // prefetch row 1 with the last row, then two rows ahead of the one emitted
  assign ram_re    = (in_fire && last_in) || (step && (nxt2 <= LastRowX));
  assign ram_raddr = (state_q == StLoad) ? RowAw'(1) : nxt2[RowAw-1:0];

  lgs_ram #(
    .Width (DataW),
    .Depth (ROWS)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (in_fire),
    .waddr_i (rows_q),
    .wdata_i (in_masked),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  for (genvar j = 0; j < DataW; j++) begin : g_lane
    if (j < COLS) begin : g_on
      localparam int unsigned Lc = (j == 0) ? COLS - 1 : j - 1;
      localparam int unsigned Rc = (j == COLS - 1) ? 0 : j + 1;
      localparam logic LEdge = (j == 0);
      localparam logic REdge = (j == COLS - 1);
      logic  l_ok;
      logic  r_ok;
      nbhd_t nb;

      assign l_ok = !LEdge || wrap_q;
      assign r_ok = !REdge || wrap_q;
      assign nb.above = {above_q[Lc] & l_ok, above_q[j], above_q[Rc] & r_ok};
      assign nb.west  = cur_q[Lc] & l_ok;
      assign nb.alive = cur_q[j];
      assign nb.east  = cur_q[Rc] & r_ok;
      assign nb.below = {below[Lc] & l_ok, below[j], below[Rc] & r_ok};

      lgs_lane u_lane (
        .nbhd_i (nb),
        .next_o (lane_row[j])
      );
    end else begin : g_off
      assign lane_row[j] = 1'b0;
    end
  end

  always_comb begin
    state_d     = state_q;
    wrap_cfg_d  = cfg_we_i ? cfg_wdata_i : wrap_cfg_q;
    wrap_d      = wrap_q;
    rows_d      = rows_q;
    emit_row_d  = emit_row_q;
    row0_d      = row0_q;
    above_d     = above_q;
    cur_d       = cur_q;
    rd_vld_d    = ram_re ? 1'b1 : (step ? 1'b0 : rd_vld_q);
    out_valid_d = out_valid_q && !out_ready_i;
    out_row_d   = out_row_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;

    case (state_q)
      StLoad: begin
        if (in_fire) begin
          if (rows_q == '0) begin
            row0_d = in_masked;
          end
          if (last_in) begin
            // sample wrap mode and seed the window around row 0
            wrap_d     = wrap_cfg_q;
            above_d    = wrap_cfg_q ? in_masked : '0;
            cur_d      = row0_q;
            emit_row_d = '0;
            rows_d     = '0;
            state_d    = StEmit;
          end else begin
            rows_d = rows_q + RowAw'(1);
          end
        end
      end
      StEmit: begin
        if (step) begin
          out_valid_d = 1'b1;
          out_row_d   = lane_row;
          out_idx_d   = IdxW'(emit_row_q);
          out_last_d  = at_last;
          above_d     = cur_q;
          cur_d       = below;
          emit_row_d  = emit_row_q + RowAw'(1);
          if (at_last) begin
            state_d = StLoad;
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      wrap_cfg_q  <= 1'b1;
      wrap_q      <= 1'b1;
      rows_q      <= '0;
      emit_row_q  <= '0;
      row0_q      <= '0;
      above_q     <= '0;
      cur_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_row_q   <= '0;
      out_idx_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      wrap_cfg_q  <= wrap_cfg_d;
      wrap_q      <= wrap_d;
      rows_q      <= rows_d;
      emit_row_q  <= emit_row_d;
      row0_q      <= row0_d;
      above_q     <= above_d;
      cur_q       <= cur_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
      out_row_q   <= out_row_d;
      out_idx_q   <= out_idx_d;
      out_last_q  <= out_last_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign row_index_o     = out_idx_q;
  assign next_row_bits_o = out_row_q;
  assign last_of_run_o   = out_last_q;

  `ASSERT_CLK(a_run_starts_at_row0,
              in_fire && last_in |=> (state_q == StEmit) && (emit_row_q == '0),
              "run did not start at row 0")
  `ASSERT_CLK(a_run_ends_clean,
              step && at_last |=> (state_q == StLoad) && (rows_q == '0),
              "run did not return to loading")
  `ASSERT_CLK(a_last_flag_row,
              out_valid_o && last_of_run_o |-> row_index_o == IdxW'(ROWS - 1),
              "last flag on wrong row")
  `ASSERT_NEVER(a_read_only_in_run, rd_vld_q && (state_q == StLoad),
                "frame read pending while loading")

endmodule

`default_nettype wire

// ===== bench/tb_life_generation_step_top.sv =====
// Self-checking bench for the life generation step block: feeds boards, checks each next row.
module tb_life_generation_step_top
  import lgs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROWS = 32;
  localparam int unsigned COLS = 64;
  localparam int NRows = ROWS;
  localparam int NCols = COLS;
  localparam logic [DataW-1:0] ColMask =
    (COLS >= DataW) ? {DataW{1'b1}} : ((64'd1 << COLS) - 64'd1);
  localparam int Settle = 2 * NRows + 4;
  localparam int QuietLimit = 5000;
  localparam bit WrapFlat = 1'b0;
  localparam bit WrapTorus = 1'b1;

  typedef struct packed {
    logic [IdxW-1:0]  row_index;
    logic [DataW-1:0] bits;
    logic             last;
  } life_row_t;

  typedef enum int {BoardNoise, BoardSparse, BoardDense, BoardShapes} board_e;
  typedef enum int {RdyOpen, RdyCoin, RdyBeat, RdyStarve} rdy_mode_e;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic             cfg_wdata_i = 1'b0;
  logic             in_valid_i = 1'b0;
  logic [DataW-1:0] row_bits_i = '0;
  logic             out_ready_i = 1'b0;
  wire logic             in_ready_o;
  wire logic             out_valid_o;
  wire logic [IdxW-1:0]  row_index_o;
  wire logic [DataW-1:0] next_row_bits_o;
  wire logic             last_of_run_o;

  wire in_xfer = in_valid_i && in_ready_o;
  wire out_xfer = out_valid_o && out_ready_i;

  life_generation_step_top #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .row_bits_i     (row_bits_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .row_index_o    (row_index_o),
    .next_row_bits_o(next_row_bits_o),
    .last_of_run_o  (last_of_run_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow of the current generation and of the edge rule.
  logic [DataW-1:0] frame_copy [ROWS];
  int               rows_seen = 0;
  bit               torus = WrapTorus;

  logic [DataW-1:0] pending_rows [$];
  life_row_t        expected_rows [$];
  int               mismatches = 0;

  function automatic bit cell_at(int r, int c);
    if (torus) begin
      r = (r + NRows) % NRows;
      c = (c + NCols) % NCols;
    end else if (r < 0 || r >= NRows || c < 0 || c >= NCols) begin
      return 1'b0;
    end
    return frame_copy[r][c];
  endfunction

  // Store one row; the last row of a board yields the whole next generation.
  function automatic void absorb_row(logic [DataW-1:0] bits);
    life_row_t nxt;
    int        count;
    frame_copy[rows_seen] = bits & ColMask;
    if (rows_seen + 1 < NRows) begin
      rows_seen++;
      return;
    end
    rows_seen = 0;
    for (int r = 0; r < NRows; r++) begin
      nxt.row_index = IdxW'(r);
      nxt.bits = '0;
      nxt.last = (r == NRows - 1);
      for (int c = 0; c < NCols; c++) begin
        count = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) count += cell_at(r + dr, c + dc);
          end
        end
        if (count == 3 || (cell_at(r, c) && count == 2)) nxt.bits[c] = 1'b1;
      end
      expected_rows.push_back(nxt);
    end
  endfunction

  task automatic check_row(life_row_t got);
    life_row_t want;
    if (expected_rows.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected row: index %0d bits %h last %0b",
                 got.row_index, got.bits, got.last);
      return;
    end
    want = expected_rows.pop_front();
    if (got.row_index !== want.row_index || got.bits !== want.bits ||
        got.last !== want.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("row mismatch: expected index %0d bits %h last %0b, got index %0d bits %h last %0b",
                 want.row_index, want.bits, want.last, got.row_index, got.bits, got.last);
    end
  endtask

  // Random board with gliders and blinkers dropped anywhere, wrapping across both edges.
  task automatic queue_generation(board_e kind);
    logic [DataW-1:0] board [ROWS];
    logic [DataW-1:0] shape;
    logic [2:0]       pat;
    int               top;
    int               shift;
    bit               glider;
    for (int r = 0; r < NRows; r++) begin
      case (kind)
        BoardNoise:  board[r] = {$urandom, $urandom};
        BoardSparse: board[r] = {$urandom, $urandom} & {$urandom, $urandom} &
                                {$urandom, $urandom};
        BoardDense:  board[r] = {$urandom, $urandom} | {$urandom, $urandom};
        default:     board[r] = ($urandom_range(0, 15) == 0) ? '1 : '0;
      endcase
    end
    repeat ($urandom_range(1, 5)) begin
      top = $urandom_range(0, NRows - 1);
      shift = $urandom_range(0, NCols - 1);
      glider = $urandom_range(0, 1);
      for (int dr = 0; dr < 3; dr++) begin
        if (glider) pat = (dr == 0) ? 3'b010 : (dr == 1) ? 3'b100 : 3'b111;
        else pat = (dr == 1) ? 3'b111 : 3'b000;
        shape = {{(DataW - 3){1'b0}}, pat};
        board[(top + dr) % NRows] |= ((shape << shift) | (shape >> (NCols - shift))) & ColMask;
      end
    end
    for (int r = 0; r < NRows; r++) pending_rows.push_back(board[r]);
  endtask

  // Hold until every row is sent and every result is back, then let the block settle.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_rows.size() != 0 || in_valid_i || expected_rows.size() != 0);
    repeat (Settle) @(negedge clk_i);
  endtask

  // Row sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      row_bits_i <= '0;
    end else begin
      if (in_xfer) absorb_row(row_bits_i);
      if (!in_valid_i || in_xfer) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_rows.size() > 0) begin
          in_valid_i <= 1'b1;
          row_bits_i <= pending_rows.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result receiver: check each transfer, stall in a pattern that changes now and then.
  rdy_mode_e rdy_mode = RdyOpen;
  int        mode_left = 0;
  int        beat = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_xfer) check_row({row_index_o, next_row_bits_o, last_of_run_o});
      if (mode_left == 0) begin
        rdy_mode = rdy_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 160);
      end else begin
        mode_left--;
      end
      beat++;
      case (rdy_mode)
        RdyOpen: out_ready_i <= 1'b1;
        RdyCoin: out_ready_i <= $urandom_range(0, 1);
        RdyBeat: out_ready_i <= (beat % 3 != 0);
        default: out_ready_i <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  int quiet = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || in_xfer || out_xfer) begin
      quiet = 0;
    end else if (quiet >= QuietLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet++;
    end
  end

  initial begin
    logic [DataW-1:0] board [ROWS];
    bit               wrap;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Hand-built board under the reset edge rule: full and empty rows, shapes
    // straddling the side and corner edges, crowding and alternating rows.
    for (int r = 0; r < NRows; r++) board[r] = '0;
    board[0] = '1;
    board[2] = {1'b1, {(DataW - 2){1'b0}}, 1'b1};
    board[8][63] = 1'b1;
    board[9][63] = 1'b1;
    board[10][63] = 1'b1;
    board[13] = 64'h8000_0000_0000_0003;
    board[16][31] = 1'b1;
    board[17][32] = 1'b1;
    board[18][32:30] = 3'b111;
    board[22][11:10] = 2'b11;
    board[23][11:10] = 2'b11;
    board[26] = 64'h0000_00FF_FF00_0000;
    board[27] = 64'h0000_00FF_FF00_0000;
    board[29] = 64'hAAAA_AAAA_AAAA_AAAA;
    board[30] = 64'h5555_5555_5555_5555;
    board[31] = {1'b1, {(DataW - 2){1'b0}}, 1'b1};
    for (int r = 0; r < NRows; r++) pending_rows.push_back(board[r]);

    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      wrap = (ph % 2 == 1) ? WrapTorus : WrapFlat;
      @(posedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_wdata_i <= wrap;
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      torus = wrap;
      @(negedge clk_i);
      repeat (4 - ph / 2) queue_generation(board_e'($urandom_range(0, 3)));
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
